// ===== rtl/lbfr_pkg.sv =====
// Shared types, codes and helpers for the LSB-first bit field reader.
// Used by every module in rtl/; depends on nothing else.
package lbfr_pkg;

   localparam int STORE_WORDS_DEF = 256;
   localparam int BYTE_LEN_W      = 11;
   localparam int CONSUMED_W      = 14;
   localparam int NEXT_WORD_W     = 9;
   localparam int SCRATCH_W       = 64;
   localparam int COUNT_W         = 6;
   localparam int WIDTH_W         = 6;
   localparam int WORD_W          = 32;

   // Command codes on the request channel.
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_REWIND = 2'd2;

   // Field width codes of a read.
   localparam logic [1:0] WC_BIT   = 2'd0;
   localparam logic [1:0] WC_BYTE  = 2'd1;
   localparam logic [1:0] WC_HALF  = 2'd2;
   localparam logic [1:0] WC_WORD  = 2'd3;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [7:0]        word_addr;
      logic [WORD_W-1:0] word_data;
      logic [1:0]        width_code;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] field_value;
      logic              out_of_bounds;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_READ,
      OP_REWIND,
      OP_NONE
   } op_type;

   // One classified command as it waits between the front and the back.
   typedef struct packed {
      op_type             op;
      logic [7:0]         addr;
      logic [WORD_W-1:0]  data;
      logic [WIDTH_W-1:0] width;
      logic [WORD_W-1:0]  mask;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   function automatic int addr_width(input int depth);
      int aw;
      aw = (depth > 1) ? $clog2(depth) : 1;
      return aw;
   endfunction

   function automatic logic [WIDTH_W-1:0] width_bits(input logic [1:0] code);
      logic [WIDTH_W-1:0] w;
      case (code)
         WC_BIT:  w = 6'd1;
         WC_BYTE: w = 6'd8;
         WC_HALF: w = 6'd16;
         WC_WORD: w = 6'd32;
         default: w = 6'd1;
      endcase
      return w;
   endfunction

   function automatic logic [WORD_W-1:0] width_mask(input logic [1:0] code);
      logic [WORD_W-1:0] m;
      case (code)
         WC_BIT:  m = 32'h0000_0001;
         WC_BYTE: m = 32'h0000_00FF;
         WC_HALF: m = 32'h0000_FFFF;
         WC_WORD: m = 32'hFFFF_FFFF;
         default: m = 32'h0000_0001;
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/lbfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Uses addr_width from lbfr_pkg for its address ports.
module lbfr_ram
   import lbfr_pkg::*;
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         we,
   input  logic [addr_width(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]             wdata,
   input  logic [addr_width(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]             rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/lbfr_front.sv =====
// Front end: accepts request words, decodes them into work items and
// queues them for the back end. Depends on lbfr_pkg.
module lbfr_front
   import lbfr_pkg::*;
#(
   parameter int STORE_WORDS = STORE_WORDS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_payload,
   output head_type head,
   input  logic     pop
);

   localparam int QUEUE_DEPTH = 2;

   item_type   slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       load_ok;
   item_type   decoded;

   // Loads beyond the store become no-ops here so that the back end never writes them.
   assign load_ok = {24'd0, req_payload.word_addr} < 32'(STORE_WORDS);

   always_comb begin
      decoded.addr  = req_payload.word_addr;
      decoded.data  = req_payload.word_data;
      decoded.width = width_bits(req_payload.width_code);
      decoded.mask  = width_mask(req_payload.width_code);
      case (req_payload.cmd)
         CMD_LOAD:   decoded.op = load_ok ? OP_LOAD : OP_NONE;
         CMD_READ:   decoded.op = OP_READ;
         CMD_REWIND: decoded.op = OP_REWIND;
         default:    decoded.op = OP_NONE;
      endcase
   end

   assign req_stall  = (cnt_ff == 2'(QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign head.valid = (cnt_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QUEUE_DEPTH))
      else $error("queue count exceeds its depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != 2'd0)
      else $error("back end popped an empty queue");

   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count missed a push");

endmodule

// ===== rtl/lbfr_back.sv =====
// Back end: executes queued items against the word store and the scratch
// register, and holds the result register. Depends on lbfr_pkg and lbfr_ram.
module lbfr_back
   import lbfr_pkg::*;
#(
   parameter int STORE_WORDS = STORE_WORDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  head_type              head,
   output logic                  pop,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [BYTE_LEN_W-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload
);

   localparam int AW = addr_width(STORE_WORDS);

   logic [BYTE_LEN_W-1:0]  byte_len_ff;
   logic [SCRATCH_W-1:0]   scratch_ff, scratch_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [NEXT_WORD_W-1:0] nw_ff, nw_in;
   logic [AW-1:0]          idx_ff, idx_in;
   logic [CONSUMED_W-1:0]  consumed_ff, consumed_in;
   logic                   byp_ff, byp_in;
   logic [WORD_W-1:0]      byp_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   we;
   logic [AW-1:0]          waddr;
   logic [AW-1:0]          raddr;
   logic [WORD_W-1:0]      ram_rdata;
   logic [WORD_W-1:0]      word_now;
   logic                   need;
   logic                   oob_hit;
   logic [CONSUMED_W:0]    sum;
   logic [CONSUMED_W-1:0]  limit;
   logic [SCRATCH_W-1:0]   topped;
   logic [COUNT_W-1:0]     count_top;
   logic [AW-1:0]          idx_step;
   logic [WIDTH_W-1:0]     w;

   assign csr_ready   = 1'b1;
   assign pop         = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign w     = head.item.width;
   assign waddr = AW'(head.item.addr);
   // The read port always addresses the word that the next top-up would take,
   // so its data is ready in the next cycle; a same-cycle load is bypassed.
   assign raddr = reset ? '0 : idx_in;

   lbfr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (head.item.data),
      .raddr (raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      word_now  = byp_ff ? byp_data_ff : ram_rdata;
      need      = count_ff < w;
      limit     = {byte_len_ff, 3'b000};
      sum       = {1'b0, consumed_ff} + {{(CONSUMED_W + 1 - WIDTH_W){1'b0}}, w};
      oob_hit   = sum > {1'b0, limit};
      topped    = need ? (scratch_ff | ({32'd0, word_now} << count_ff[4:0])) : scratch_ff;
      count_top = need ? count_ff + 6'd32 : count_ff;
      idx_step  = ((idx_ff == AW'(STORE_WORDS - 1)) || (nw_ff == '1)) ? '0
                                                                      : idx_ff + AW'(1);

      scratch_in  = scratch_ff;
      count_in    = count_ff;
      nw_in       = nw_ff;
      idx_in      = idx_ff;
      consumed_in = consumed_ff;
      we          = 1'b0;
      rsp_in      = '0;

      if (pop) begin
         case (head.item.op)
            OP_LOAD: begin
               we = 1'b1;
            end
            OP_READ: begin
               if (oob_hit) begin
                  rsp_in.out_of_bounds = 1'b1;
               end else begin
                  rsp_in.field_value = topped[WORD_W-1:0] & head.item.mask;
                  scratch_in         = topped >> w;
                  count_in           = count_top - w;
                  consumed_in        = consumed_ff + {{(CONSUMED_W - WIDTH_W){1'b0}}, w};
                  if (need) begin
                     nw_in  = nw_ff + 9'd1;
                     idx_in = idx_step;
                  end
               end
            end
            OP_REWIND: begin
               scratch_in  = '0;
               count_in    = '0;
               nw_in       = '0;
               idx_in      = '0;
               consumed_in = '0;
            end
            default: begin
            end
         endcase
      end

      byp_in = we && (waddr == raddr);

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_len_ff  <= '0;
         scratch_ff   <= '0;
         count_ff     <= '0;
         nw_ff        <= '0;
         idx_ff       <= '0;
         consumed_ff  <= '0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            byte_len_ff <= csr_data;
         end
         scratch_ff   <= scratch_in;
         count_ff     <= count_in;
         nw_ff        <= nw_in;
         idx_ff       <= idx_in;
         consumed_ff  <= consumed_in;
         byp_ff       <= byp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= head.item.data;
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   a_scratch_clean: assert property (@(posedge clock) disable iff (reset)
      (scratch_ff >> count_ff) == '0)
      else $error("scratch register holds bits above its count");

   a_rewind_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && head.item.op == OP_REWIND) |=>
         (count_ff == '0 && nw_ff == '0 && consumed_ff == '0 && idx_ff == '0))
      else $error("rewind left read position state behind");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      32'(idx_ff) < 32'(STORE_WORDS))
      else $error("prefetch index left the store");

   a_consumed_only_on_read: assert property (@(posedge clock) disable iff (reset)
      !(pop && (head.item.op == OP_READ || head.item.op == OP_REWIND)) |=>
         $stable(consumed_ff))
      else $error("consumed count moved without a read or rewind");

endmodule

// ===== rtl/lsb_first_bit_field_reader.sv =====
// LSB-first bit field reader, top level. Depends on lbfr_pkg, lbfr_front, lbfr_back.
// A result is registered when the back end pops its request word from the queue.
// Throughput: one request per cycle while rsp_stall is low, with loads, reads and
// rewinds mixed freely; set by the scratch update loop and the single store read port.
// Reset is synchronous and clears read position, scratch, length and handshake state;
// the word store is not cleared and must be loaded before its words are read.
module lsb_first_bit_field_reader
   import lbfr_pkg::*;
#(
   parameter int STORE_WORDS = STORE_WORDS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [BYTE_LEN_W-1:0] csr_data
);

   head_type head;
   logic     pop;

   lbfr_front #(
      .STORE_WORDS (STORE_WORDS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .head        (head),
      .pop         (pop)
   );

   lbfr_back #(
      .STORE_WORDS (STORE_WORDS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
